>>> sv/ray_pair_intersect_window_2d_macros.svh
// Assertion helpers for the ray pair window block
`ifndef RAY_PAIR_INTERSECT_WINDOW_2D_MACROS_SVH
`define RAY_PAIR_INTERSECT_WINDOW_2D_MACROS_SVH

// implication checked on every clock edge out of reset
`define RPIW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition that holds on every clock edge out of reset
`define RPIW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

>>> sv/rpiw_pkg.sv
package rpiw_pkg;

  localparam int WIN_BITS = 50;

  localparam logic signed [WIN_BITS-1:0] WINDOW_LOW_RESET  = 50'sd200000000000000;
  localparam logic signed [WIN_BITS-1:0] WINDOW_HIGH_RESET = 50'sd400000000000000;

  typedef enum logic [0:0] {
    REG_WINDOW_LOW  = 1'b0,
    REG_WINDOW_HIGH = 1'b1
  } cfg_reg_t;

endpackage

>>> sv/rpiw_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module rpiw_div #(
  parameter int N  = 8,
  parameter int D  = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [N-1:0]  num_i,
  input  logic [D-1:0]  den_i,
  input  logic [SW-1:0] side_i,
  output logic          out_vld,
  output logic [N-1:0]  quo_o,
  output logic [D-1:0]  rem_o,
  output logic [D-1:0]  den_o,
  output logic [SW-1:0] side_o
);

  logic [D-1:0]  rem_r  [N];
  logic [D-1:0]  den_r  [N];
  logic [N-1:0]  nq_r   [N];
  logic [SW-1:0] side_r [N];
  logic          vld_r  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [D-1:0]  rem_p;
    logic [D-1:0]  den_p;
    logic [N-1:0]  nq_p;
    logic [SW-1:0] side_p;
    logic          vld_p;
    logic [D:0]    trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_p  = '0;
      assign den_p  = den_i;
      assign nq_p   = num_i;
      assign side_p = side_i;
      assign vld_p  = in_vld;
    end else begin : g_next
      assign rem_p  = rem_r[i-1];
      assign den_p  = den_r[i-1];
      assign nq_p   = nq_r[i-1];
      assign side_p = side_r[i-1];
      assign vld_p  = vld_r[i-1];
    end

    assign trial = {rem_p, nq_p[N-1]};
    assign ge    = trial >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? D'(trial - {1'b0, den_p}) : trial[D-1:0];
        nq_r[i]   <= {nq_p[N-2:0], ge};
        den_r[i]  <= den_p;
        side_r[i] <= side_p;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_p;
      end
    end
  end

  assign out_vld = vld_r[N-1];
  assign quo_o   = nq_r[N-1];
  assign rem_o   = rem_r[N-1];
  assign den_o   = den_r[N-1];
  assign side_o  = side_r[N-1];

endmodule

>>> sv/ray_pair_intersect_window_2d.sv
// Channel | Handshake          | Payload
// in      | in_valid/in_stall  | first/second pos x,y and vel x,y
// out     | out_valid/out_stall| crosses_inside
// cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One pair per cycle unless a stalled result holds the pipeline. A pair passes stages
// A, B, C, the crossing-time dividers, D, the remainder-term dividers and out_valid_r.
// Reset clears valid bits and loads the window defaults; no clearing pass.
// A stalled result freezes the whole pipeline; in_stall follows it directly.
module ray_pair_intersect_window_2d
  import rpiw_pkg::*;
#(
  parameter int POS_BITS = 50,
  parameter int VEL_BITS = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [POS_BITS-1:0] in_first_pos_x,
  input  logic signed [POS_BITS-1:0] in_first_pos_y,
  input  logic signed [VEL_BITS-1:0] in_first_vel_x,
  input  logic signed [VEL_BITS-1:0] in_first_vel_y,
  input  logic signed [POS_BITS-1:0] in_second_pos_x,
  input  logic signed [POS_BITS-1:0] in_second_pos_y,
  input  logic signed [VEL_BITS-1:0] in_second_vel_x,
  input  logic signed [VEL_BITS-1:0] in_second_vel_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_crosses_inside,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [0:0]                 cfg_index,
  input  logic [WIN_BITS-1:0]        cfg_data
);

`include "ray_pair_intersect_window_2d_macros.svh"

  localparam int DXW  = POS_BITS + 1;
  localparam int DETW = 2 * VEL_BITS + 1;
  localparam int PRW  = DXW + VEL_BITS;
  localparam int TNW  = PRW + 1;
  localparam int AW   = TNW;
  localparam int CW   = 2 * VEL_BITS;
  localparam int BW   = VEL_BITS;
  localparam int RRW  = CW + BW;
  localparam int SMW  = AW + BW + 2;
  localparam int EW   = SMW + 1;
  localparam int BDW  = ((WIN_BITS > POS_BITS) ? WIN_BITS : POS_BITS) + 1;
  localparam int CMPW = EW + BDW;
  localparam int AXW  = 1 + BW + 2 * BDW;
  localparam int T4XW = 1 + SMW + 2 * BDW;
  localparam int T4YW = 2 + SMW + 2 * BDW;

  logic out_valid_r, crosses_r;
  logic adv;
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // configuration
  logic signed [WIN_BITS-1:0] win_low_r, win_high_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r  <= WINDOW_LOW_RESET;
      win_high_r <= WINDOW_HIGH_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LOW:  win_low_r  <= cfg_data;
        REG_WINDOW_HIGH: win_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage A: differences and determinant
  logic                       a_vld_r;
  logic signed [POS_BITS-1:0] a_x1_r, a_y1_r;
  logic signed [DXW-1:0]      a_dx_r, a_dy_r;
  logic signed [VEL_BITS-1:0] a_vx1_r, a_vy1_r, a_vx2_r, a_vy2_r;
  logic signed [DETW-1:0]     a_det_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x1_r  <= in_first_pos_x;
      a_y1_r  <= in_first_pos_y;
      a_dx_r  <= DXW'(in_first_pos_x) - DXW'(in_second_pos_x);
      a_dy_r  <= DXW'(in_first_pos_y) - DXW'(in_second_pos_y);
      a_vx1_r <= in_first_vel_x;
      a_vy1_r <= in_first_vel_y;
      a_vx2_r <= in_second_vel_x;
      a_vy2_r <= in_second_vel_y;
      a_det_r <= DETW'(in_first_vel_y) * DETW'(in_second_vel_x)
               - DETW'(in_first_vel_x) * DETW'(in_second_vel_y);
    end
  end

  // stage B: cross products, window offsets
  logic                   b_vld_r;
  logic signed [PRW-1:0]  b_pa_r, b_pb_r, b_pc_r, b_pd_r;
  logic signed [DETW-1:0] b_det_r;
  logic signed [VEL_BITS-1:0] b_vx1_r, b_vy1_r;
  logic signed [BDW-1:0]  b_lox_r, b_hix_r, b_loy_r, b_hiy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_pa_r  <= PRW'(a_dx_r) * PRW'(a_vy2_r);
      b_pb_r  <= PRW'(a_dy_r) * PRW'(a_vx2_r);
      b_pc_r  <= PRW'(a_dx_r) * PRW'(a_vy1_r);
      b_pd_r  <= PRW'(a_dy_r) * PRW'(a_vx1_r);
      b_det_r <= a_det_r;
      b_vx1_r <= a_vx1_r;
      b_vy1_r <= a_vy1_r;
      b_lox_r <= BDW'(win_low_r) - BDW'(a_x1_r);
      b_hix_r <= BDW'(win_high_r) - BDW'(a_x1_r);
      b_loy_r <= BDW'(win_low_r) - BDW'(a_y1_r);
      b_hiy_r <= BDW'(win_high_r) - BDW'(a_y1_r);
    end
  end

  // stage C: numerators, filters, magnitudes
  logic signed [TNW-1:0] tn, sn;
  logic signed [TNW-1:0] tn_neg;
  logic signed [DETW-1:0] det_neg;
  logic                  det_n, tn_n;
  assign tn      = TNW'(b_pa_r) - TNW'(b_pb_r);
  assign sn      = TNW'(b_pc_r) - TNW'(b_pd_r);
  assign tn_neg  = -tn;
  assign det_neg = -b_det_r;
  assign det_n   = b_det_r[DETW-1];
  assign tn_n    = tn[TNW-1];

  logic                  c_vld_r, c_ok_r, c_sx_r, c_sy_r;
  logic [AW-1:0]         c_ma_r;
  logic [CW-1:0]         c_mc_r;
  logic [BW-1:0]         c_mbx_r, c_mby_r;
  logic signed [BDW-1:0] c_lox_r, c_hix_r, c_loy_r, c_hiy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_ok_r  <= (b_det_r != '0) && (tn != '0) && (sn != '0)
              && (tn_n == det_n) && (sn[TNW-1] == det_n);
      c_ma_r  <= tn_n ? AW'(tn_neg) : AW'(tn);
      c_mc_r  <= (b_det_r == '0) ? CW'(1) : (det_n ? CW'(det_neg) : CW'(b_det_r));
      c_mbx_r <= b_vx1_r[BW-1] ? BW'(-b_vx1_r) : BW'(b_vx1_r);
      c_mby_r <= b_vy1_r[BW-1] ? BW'(-b_vy1_r) : BW'(b_vy1_r);
      c_sx_r  <= tn_n ^ b_vx1_r[BW-1] ^ det_n;
      c_sy_r  <= tn_n ^ b_vy1_r[BW-1] ^ det_n;
      c_lox_r <= b_lox_r;
      c_hix_r <= b_hix_r;
      c_loy_r <= b_loy_r;
      c_hiy_r <= b_hiy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  // crossing time and velocity quotients
  logic          m_vld, bx_vld, by_vld;
  logic [AW-1:0] qa, qbx, qby;
  logic [CW-1:0] ra, rbx, rby, mc, den_bx, den_by;
  logic [0:0]    m_side;
  logic [AXW-1:0] bx_side, by_side;

  rpiw_div #(.N(AW), .D(CW), .SW(1)) u_div_t (
    .clk, .rst_n, .en(adv), .in_vld(c_vld_r),
    .num_i(c_ma_r), .den_i(c_mc_r), .side_i(c_ok_r),
    .out_vld(m_vld), .quo_o(qa), .rem_o(ra), .den_o(mc), .side_o(m_side)
  );

  rpiw_div #(.N(AW), .D(CW), .SW(AXW)) u_div_bx (
    .clk, .rst_n, .en(adv), .in_vld(c_vld_r),
    .num_i(AW'(c_mbx_r)), .den_i(c_mc_r), .side_i({c_sx_r, c_mbx_r, c_lox_r, c_hix_r}),
    .out_vld(bx_vld), .quo_o(qbx), .rem_o(rbx), .den_o(den_bx), .side_o(bx_side)
  );

  rpiw_div #(.N(AW), .D(CW), .SW(AXW)) u_div_by (
    .clk, .rst_n, .en(adv), .in_vld(c_vld_r),
    .num_i(AW'(c_mby_r)), .den_i(c_mc_r), .side_i({c_sy_r, c_mby_r, c_loy_r, c_hiy_r}),
    .out_vld(by_vld), .quo_o(qby), .rem_o(rby), .den_o(den_by), .side_o(by_side)
  );

  // stage D: split products
  logic                  d_vld_r, d_ok_r, d_sx_r, d_sy_r;
  logic [CW-1:0]         d_mc_r;
  logic [AW+BW-1:0]      d_pqx_r, d_pqy_r;
  logic [CW+BW-1:0]      d_rqx_r, d_rqy_r;
  logic [RRW-1:0]        d_rrx_r, d_rry_r;
  logic signed [BDW-1:0] d_lox_r, d_hix_r, d_loy_r, d_hiy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_ok_r  <= m_side[0];
      d_mc_r  <= mc;
      d_sx_r  <= bx_side[AXW-1];
      d_sy_r  <= by_side[AXW-1];
      d_pqx_r <= (AW+BW)'(qa) * (AW+BW)'(bx_side[AXW-2 -: BW]);
      d_pqy_r <= (AW+BW)'(qa) * (AW+BW)'(by_side[AXW-2 -: BW]);
      d_rqx_r <= (CW+BW)'(ra) * (CW+BW)'(qbx[BW-1:0]);
      d_rqy_r <= (CW+BW)'(ra) * (CW+BW)'(qby[BW-1:0]);
      d_rrx_r <= RRW'(ra) * RRW'(rbx[BW-1:0]);
      d_rry_r <= RRW'(ra) * RRW'(rby[BW-1:0]);
      d_lox_r <= bx_side[2*BDW-1:BDW];
      d_hix_r <= bx_side[BDW-1:0];
      d_loy_r <= by_side[2*BDW-1:BDW];
      d_hiy_r <= by_side[BDW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= m_vld && bx_vld && by_vld;
    end
  end

  // remainder term divide
  logic [SMW-1:0] sumx, sumy;
  assign sumx = SMW'(d_pqx_r) + SMW'(d_rqx_r);
  assign sumy = SMW'(d_pqy_r) + SMW'(d_rqy_r);

  logic            ex_vld, ey_vld;
  logic [RRW-1:0]  q4x, q4y;
  logic [CW-1:0]   r4x, r4y, dx4, dy4;
  logic [T4XW-1:0] ex_side;
  logic [T4YW-1:0] ey_side;

  rpiw_div #(.N(RRW), .D(CW), .SW(T4XW)) u_div_rx (
    .clk, .rst_n, .en(adv), .in_vld(d_vld_r),
    .num_i(d_rrx_r), .den_i(d_mc_r), .side_i({d_sx_r, sumx, d_lox_r, d_hix_r}),
    .out_vld(ex_vld), .quo_o(q4x), .rem_o(r4x), .den_o(dx4), .side_o(ex_side)
  );

  rpiw_div #(.N(RRW), .D(CW), .SW(T4YW)) u_div_ry (
    .clk, .rst_n, .en(adv), .in_vld(d_vld_r),
    .num_i(d_rry_r), .den_i(d_mc_r), .side_i({d_ok_r, d_sy_r, sumy, d_loy_r, d_hiy_r}),
    .out_vld(ey_vld), .quo_o(q4y), .rem_o(r4y), .den_o(dy4), .side_o(ey_side)
  );

  // final stage: signed displacement and window test
  logic [SMW-1:0]         magx, magy;
  logic signed [EW-1:0]   ex, ey;
  logic signed [CMPW-1:0] cex, cey, clox, chix, cloy, chiy;
  logic                   hit;

  assign magx = ex_side[T4XW-2 -: SMW] + SMW'(q4x);
  assign magy = ey_side[T4YW-3 -: SMW] + SMW'(q4y);
  assign ex   = ex_side[T4XW-1] ? -EW'(magx) : EW'(magx);
  assign ey   = ey_side[T4YW-2] ? -EW'(magy) : EW'(magy);
  assign cex  = CMPW'(ex);
  assign cey  = CMPW'(ey);
  assign clox = CMPW'($signed(ex_side[2*BDW-1:BDW]));
  assign chix = CMPW'($signed(ex_side[BDW-1:0]));
  assign cloy = CMPW'($signed(ey_side[2*BDW-1:BDW]));
  assign chiy = CMPW'($signed(ey_side[BDW-1:0]));
  assign hit  = ey_side[T4YW-1] && (clox < cex) && (cex < chix)
             && (cloy < cey) && (cey < chiy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ex_vld && ey_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      crosses_r <= hit;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_crosses_inside = crosses_r;

  // divider lanes must stay in lockstep
  `RPIW_ASSERT_ALWAYS(a_div_lockstep, (m_vld == bx_vld) && (bx_vld == by_vld)
                      && (!m_vld || ((den_bx == mc) && (den_by == mc))),
                      "crossing divider lanes out of step")
  `RPIW_ASSERT_ALWAYS(a_rem_lockstep, (ex_vld == ey_vld) && (r4x < dx4 || !ex_vld)
                      && (r4y < dy4 || !ey_vld), "remainder divider lanes out of step")
  `RPIW_ASSERT_IMPL(a_stall_freeze, out_valid && out_stall,
                    $stable(c_vld_r) && $stable(d_vld_r) && out_valid,
                    "pipeline moved under output stall")

endmodule
